FILE: rtl/plasma_pixel_palette_generator_unit_macros.svh
// assertion macros for the plasma pixel palette generator
// expects clk and rst in the scope of the including module
`ifndef PLASMA_PIXEL_PALETTE_GENERATOR_UNIT_MACROS_SVH
`define PLASMA_PIXEL_PALETTE_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication
`define PPG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PPG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/ppg_pkg.sv
// constants, register codes and the sine entry function of the plasma generator
// no dependencies
`timescale 1ns / 1ps
package ppg_pkg;

  localparam int unsigned CoordW = 4;
  localparam int unsigned FrameW = 16;
  localparam int unsigned RgbW   = 24;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [2:0] REG_COLOR_COUNT = 3'd0;
  localparam logic [2:0] REG_COLOR_ZERO  = 3'd1;
  localparam logic [2:0] REG_COLOR_ONE   = 3'd2;
  localparam logic [2:0] REG_COLOR_TWO   = 3'd3;
  localparam logic [2:0] REG_COLOR_THREE = 3'd4;
  localparam logic [2:0] REG_COLOR_FOUR  = 3'd5;

  localparam logic [23:0] COLOR_ZERO_RST  = 24'h492d61;
  localparam logic [23:0] COLOR_ONE_RST   = 24'h048091;
  localparam logic [23:0] COLOR_TWO_RST   = 24'h61c155;
  localparam logic [23:0] COLOR_THREE_RST = 24'hf2d43f;
  localparam logic [23:0] COLOR_FOUR_RST  = 24'hd1026c;

  localparam logic [26:0] DEG_TURN       = 27'd11930465;
  localparam logic [26:0] HALF_DEG_TURN  = 27'd5965232;
  localparam logic [26:0] FRAME_STEP_ONE = 27'd7355802;
  localparam logic [26:0] FRAME_STEP_TWO = 27'd43369936;
  localparam logic [5:0]  COORD_BASE     = 6'd20;

  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  typedef logic signed [15:0] sine_t;

  // sine of entry i of a table with 2^aw entries over one turn, q1.15
  function automatic sine_t sine_entry(input int unsigned i, input int unsigned aw);
    logic [63:0] f, r, x, x2, t, s, v;
    logic [1:0]  quad;
    f = 64'(i) << (32 - aw);
    quad = f[31:30];
    r = f & (ONE_Q30 - 64'd1);
    if (quad[0]) begin
      r = ONE_Q30 - r;
    end
    x  = (r * PI_HALF_Q30) >> 30;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((t * x2) >> 30) / 64'd110;
    t  = ONE_Q30 - ((t * x2) >> 30) / 64'd72;
    t  = ONE_Q30 - ((t * x2) >> 30) / 64'd42;
    t  = ONE_Q30 - ((t * x2) >> 30) / 64'd20;
    t  = ONE_Q30 - ((t * x2) >> 30) / 64'd6;
    s  = (x * t) >> 30;
    v  = (s * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return quad[1] ? -sine_t'(v[15:0]) : sine_t'(v[15:0]);
  endfunction

endpackage

FILE: rtl/ppg_in_if.sv
// request channel of the plasma generator: pixel coordinates and frame
// depends on ppg_pkg
`timescale 1ns / 1ps
interface ppg_in_if;
  logic                           valid;
  logic                           ready;
  logic [ppg_pkg::CoordW-1:0]     pixel_x;
  logic [ppg_pkg::CoordW-1:0]     pixel_y;
  logic [ppg_pkg::FrameW-1:0]     frame_number;

  modport source (output valid, pixel_x, pixel_y, frame_number, input ready);
  modport sink   (input valid, pixel_x, pixel_y, frame_number, output ready);
endinterface

FILE: rtl/ppg_out_if.sv
// result channel of the plasma generator: pixel colour and palette index
// depends on ppg_pkg
`timescale 1ns / 1ps
interface ppg_out_if;
  logic                       valid;
  logic                       ready;
  logic [ppg_pkg::RgbW-1:0]   pixel_rgb;
  logic [ppg_pkg::IdxW-1:0]   palette_index;

  modport source (output valid, pixel_rgb, palette_index, input ready);
  modport sink   (input valid, pixel_rgb, palette_index, output ready);
endinterface

FILE: rtl/plasma_pixel_palette_generator_unit.sv
// plasma pixel colour generator: waves from a shared sine rom, gradient palette
// depends on ppg_pkg, ppg_in_if, ppg_out_if and the macros header
// the palette walk moves the anchor offset on by 0 to 4 before the blend
// throughput: one request at a time, the next one is taken the cycle after the result
// leaves; the rate is set by one shared multiplier and one sine rom read port
// reset: synchronous active-high rst, sequencer idles, configuration registers take their defaults
`timescale 1ns / 1ps
`include "plasma_pixel_palette_generator_unit_macros.svh"
module plasma_pixel_palette_generator_unit #(
  parameter int unsigned GRID_SIZE        = 16,
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [ppg_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [ppg_pkg::RgbW-1:0]      cfg_data,
  ppg_in_if.sink                        pix_in,
  ppg_out_if.source                     pix_out
);
  import ppg_pkg::*;

  localparam int unsigned AW = $clog2(SINE_TABLE_DEPTH);
  localparam logic [8:0] GMAX = 9'(GRID_SIZE - 1);

  // sequencer codes
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PH1   = 4'd1;
  localparam logic [3:0] ST_PH2   = 4'd2;
  localparam logic [3:0] ST_PH3   = 4'd3;
  localparam logic [3:0] ST_PH4   = 4'd4;
  localparam logic [3:0] ST_PH5   = 4'd5;
  localparam logic [3:0] ST_PH6   = 4'd6;
  localparam logic [3:0] ST_PH7   = 4'd7;
  localparam logic [3:0] ST_SUM   = 4'd8;
  localparam logic [3:0] ST_ADD3  = 4'd9;
  localparam logic [3:0] ST_WRAP  = 4'd10;
  localparam logic [3:0] ST_LOOP  = 4'd11;
  localparam logic [3:0] ST_SELA  = 4'd12;
  localparam logic [3:0] ST_SELC  = 4'd13;
  localparam logic [3:0] ST_BLEND = 4'd14;
  localparam logic [3:0] ST_DONE  = 4'd15;

  // sine rom, built at elaboration
  typedef logic signed [15:0] rom_t [SINE_TABLE_DEPTH];

  function automatic rom_t build_rom();
    rom_t tbl;
    for (int unsigned i = 0; i < SINE_TABLE_DEPTH; i++) begin
      tbl[i] = sine_entry(i, AW);
    end
    return tbl;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  logic [3:0]          state;
  logic [3:0]          state_next;

  // configuration registers
  logic [2:0]          color_count;
  logic [23:0]         anchor [5];

  // request operands
  logic [5:0]          xc;
  logic [5:0]          yc;
  logic [17:0]         diag;
  logic [15:0]         frame;
  logic [2:0]          count;
  logic [9:0]          step4;

  // shared multiplier
  logic signed [34:0]  mul_a;
  logic signed [26:0]  mul_b;
  logic signed [61:0]  prod;

  // rom port
  logic [31:0]         rom_phase;
  logic [AW-1:0]       rom_addr;
  logic signed [15:0]  rom_q;

  logic signed [15:0]  c1;
  logic signed [15:0]  c2;
  logic [32:0]         kx;
  logic [32:0]         ky;
  logic signed [18:0]  acc;

  // palette walk
  logic [7:0]          pal_p;
  logic [2:0]          pal_o;
  logic [7:0]          mix;
  logic [23:0]         col_a;
  logic [23:0]         col_c;
  logic [1:0]          ch;
  logic [23:0]         rgb_q;
  logic [7:0]          idx_q;

  logic [2:0]          sel;
  logic [23:0]         sel_color;
  logic [2:0]          o_inc;
  logic [9:0]          p4;
  logic [18:0]         biased;
  logic [9:0]          wave_sum;
  logic [7:0]          idx_wrap;
  logic [10:0]         mix_full;
  logic [7:0]          ch_a;
  logic [7:0]          ch_c;
  logic [7:0]          ch_c_prev;
  logic signed [17:0]  blend_sum;
  logic [3:0]          x_cl;
  logic [3:0]          y_cl;
  logic [2:0]          cnt_cl;

  logic                req_acc;

  assign req_acc = pix_in.valid && pix_in.ready;
  assign pix_in.ready = (state == ST_IDLE);
  assign pix_out.valid = (state == ST_DONE);
  assign pix_out.pixel_rgb = rgb_q;
  assign pix_out.palette_index = idx_q;

  // configuration writes, indexes past the last register are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      color_count <= 3'd5;
      anchor[0] <= COLOR_ZERO_RST;
      anchor[1] <= COLOR_ONE_RST;
      anchor[2] <= COLOR_TWO_RST;
      anchor[3] <= COLOR_THREE_RST;
      anchor[4] <= COLOR_FOUR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COLOR_COUNT: color_count <= cfg_data[2:0];
        REG_COLOR_ZERO:  anchor[0] <= cfg_data;
        REG_COLOR_ONE:   anchor[1] <= cfg_data;
        REG_COLOR_TWO:   anchor[2] <= cfg_data;
        REG_COLOR_THREE: anchor[3] <= cfg_data;
        REG_COLOR_FOUR:  anchor[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  // off-grid coordinates saturate, count outside 1..5 is clamped
  always_comb begin
    x_cl = (9'(pix_in.pixel_x) > GMAX) ? GMAX[3:0] : pix_in.pixel_x;
    y_cl = (9'(pix_in.pixel_y) > GMAX) ? GMAX[3:0] : pix_in.pixel_y;
    if (color_count == 3'd0) begin
      cnt_cl = 3'd1;
    end else if (color_count > 3'd5) begin
      cnt_cl = 3'd5;
    end else begin
      cnt_cl = color_count;
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_PH1: begin
        mul_a = 35'(frame);
        mul_b = FRAME_STEP_ONE;
      end
      ST_PH2: begin
        mul_a = 35'(frame);
        mul_b = FRAME_STEP_TWO;
      end
      ST_PH3: begin
        mul_a = 35'(xc);
        mul_b = DEG_TURN;
      end
      ST_PH4: begin
        mul_a = 35'(yc);
        mul_b = DEG_TURN;
      end
      ST_PH5: begin
        mul_a = 35'(kx);
        mul_b = 27'(c1);
      end
      ST_PH6: begin
        mul_a = 35'(ky);
        mul_b = 27'(c2);
      end
      ST_PH7: begin
        mul_a = 35'(diag);
        mul_b = HALF_DEG_TURN;
      end
      ST_BLEND: begin
        mul_a = 35'($signed({1'b0, ch_a}) - $signed({1'b0, ch_c}));
        mul_b = 27'(mix);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // rom address from the phase that the last product holds
  always_comb begin
    rom_phase = prod[31:0];
    case (state)
      ST_PH3:          rom_phase = 32'd0 - prod[31:0];
      ST_PH6, ST_PH7:  rom_phase = prod[46:15];
      default: ;
    endcase
    rom_addr = rom_phase[31 -: AW];
  end

  always_ff @(posedge clk) begin
    rom_q <= SINE_ROM[rom_addr];
  end

  // wave sum rounded to the palette index, sum stays below 4*255
  always_comb begin
    biased = 19'(acc + 19'sd98432);
    wave_sum = biased[17:8];
    if (wave_sum >= 10'd765) begin
      idx_wrap = 8'(wave_sum - 10'd765);
    end else if (wave_sum >= 10'd510) begin
      idx_wrap = 8'(wave_sum - 10'd510);
    end else if (wave_sum >= 10'd255) begin
      idx_wrap = 8'(wave_sum - 10'd255);
    end else begin
      idx_wrap = wave_sum[7:0];
    end
  end

  // anchor select, one read a cycle
  always_comb begin
    p4 = {pal_p, 2'b00};
    o_inc = pal_o + 3'd1;
    if (state == ST_SELA) begin
      sel = (o_inc >= count) ? o_inc - count : o_inc;
    end else begin
      sel = (pal_o >= count) ? pal_o - count : pal_o;
    end
    case (sel)
      3'd0:    sel_color = anchor[0];
      3'd1:    sel_color = anchor[1];
      3'd2:    sel_color = anchor[2];
      3'd3:    sel_color = anchor[3];
      default: sel_color = anchor[4];
    endcase
    mix_full = 11'(pal_p) * 11'(count);
  end

  // blend channel ch issues its product, channel ch-1 is finished
  always_comb begin
    ch_a = col_a[8*ch +: 8];
    ch_c = col_c[8*ch +: 8];
    ch_c_prev = col_c[8*(ch - 2'd1) +: 8];
    blend_sum = $signed({2'b00, ch_c_prev, 8'b0}) - $signed(18'(ch_c_prev))
                + 18'(prod);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (req_acc) state_next = ST_PH1;
      ST_PH1:   state_next = ST_PH2;
      ST_PH2:   state_next = ST_PH3;
      ST_PH3:   state_next = ST_PH4;
      ST_PH4:   state_next = ST_PH5;
      ST_PH5:   state_next = ST_PH6;
      ST_PH6:   state_next = ST_PH7;
      ST_PH7:   state_next = ST_SUM;
      ST_SUM:   state_next = ST_ADD3;
      ST_ADD3:  state_next = ST_WRAP;
      ST_WRAP:  state_next = ST_LOOP;
      ST_LOOP:  if (!(p4 > step4)) state_next = ST_SELA;
      ST_SELA:  state_next = ST_SELC;
      ST_SELC:  state_next = ST_BLEND;
      ST_BLEND: if (ch == 2'd3) state_next = ST_DONE;
      ST_DONE:  if (pix_out.ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        xc    <= COORD_BASE + 6'(x_cl);
        yc    <= COORD_BASE + 6'(y_cl);
        diag  <= 18'(COORD_BASE + 6'(x_cl)) + 18'(COORD_BASE + 6'(y_cl))
                 + 18'(pix_in.frame_number) * 18'd3;
        frame <= pix_in.frame_number;
        count <= cnt_cl;
        case (cnt_cl)
          3'd1:    step4 <= 10'd1020;
          3'd2:    step4 <= 10'd510;
          3'd3:    step4 <= 10'd340;
          3'd4:    step4 <= 10'd255;
          default: step4 <= 10'd204;
        endcase
      end
      ST_PH3:  c1 <= rom_q;
      ST_PH4: begin
        c2 <= rom_q;
        kx <= prod[32:0];
      end
      ST_PH5:  ky <= prod[32:0];
      ST_PH7:  acc <= 19'(rom_q);
      ST_SUM:  acc <= acc + 19'(rom_q);
      ST_ADD3: acc <= acc + 19'(rom_q);
      ST_WRAP: begin
        idx_q <= idx_wrap;
        pal_p <= idx_wrap;
        pal_o <= 3'd0;
      end
      ST_LOOP: begin
        if (p4 > step4) begin
          pal_p <= 8'((p4 - step4) >> 2);
          pal_o <= o_inc;
        end
      end
      ST_SELA: begin
        col_a <= sel_color;
        mix <= (mix_full > 11'd255) ? 8'd255 : mix_full[7:0];
        ch <= 2'd0;
      end
      ST_SELC:  col_c <= sel_color;
      ST_BLEND: begin
        if (ch != 2'd0) begin
          rgb_q[8*(ch - 2'd1) +: 8] <= blend_sum[15:8];
        end
        ch <= ch + 2'd1;
      end
      default: ;
    endcase
  end

  `PPG_ASSERT_NXT(a_req_starts, req_acc, state == ST_PH1, "request did not start the sequencer")
  `PPG_ASSERT_NOW(a_idx_range, pix_out.valid, idx_q < 8'd255, "palette index out of range")
  `PPG_ASSERT_NOW(a_one_at_a_time, pix_out.valid, !pix_in.ready, "request taken while result waits")
  `PPG_ASSERT_NOW(a_walk_bound, state == ST_SELA, pal_o < count, "palette walk overran the anchors")

endmodule

FILE: tb/sv/tb_plasma_pixel_palette_generator_unit.sv
// self-checking bench for the plasma pixel palette generator: directed table, then random pixels
// under several palette settings, results checked against an in-bench wave and palette predictor
// depends on ppg_pkg, ppg_in_if, ppg_out_if and the generator unit
`timescale 1ns / 1ps
module tb_plasma_pixel_palette_generator_unit;
  import ppg_pkg::*;

  // register slots past the last color, writes there must be dropped
  localparam logic [2:0] REG_SPARE_SIX   = 3'd6;
  localparam logic [2:0] REG_SPARE_SEVEN = 3'd7;

  localparam int unsigned ROM_DEPTH  = 1024;
  localparam int unsigned RAND_ITEMS = 220;   // per palette setting
  localparam int unsigned SETTINGS_N = 8;
  localparam int unsigned IDLE_LIMIT = 4000;  // cycles with no handshake at all
  localparam int unsigned HOLD_LEN   = 300;   // long receiver hold-off
  localparam int unsigned DRAIN_WAIT = 25;    // a bit over the worst latency

  typedef struct packed {
    logic [RgbW-1:0] rgb;
    logic [IdxW-1:0] idx;
  } pixel_color_t;

  // one row of the directed table: optional register write, then one request
  typedef struct {
    bit              wr;
    logic [2:0]      reg_idx;
    logic [RgbW-1:0] reg_data;
    logic [3:0]      x;
    logic [3:0]      y;
    logic [15:0]     frame;
    bit              has_rgb;
    logic [RgbW-1:0] rgb;
  } plasma_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [RgbW-1:0] cfg_data = '0;

  ppg_in_if  pix_in ();
  ppg_out_if pix_out ();

  plasma_pixel_palette_generator_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pix_in   (pix_in),
    .pix_out  (pix_out)
  );

  always #2 clk = ~clk;

  // mirror of the palette registers
  logic [2:0]      pal_count;
  logic [RgbW-1:0] pal_anchor [5];

  int sine_rom [ROM_DEPTH];
  pixel_color_t pending_colors [$];
  int unsigned fail_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned idle_cycles = 0;

  // sender burst state
  int unsigned burst_left = 0;

  // receiver stall state
  int unsigned hold_cnt = 0;
  bit hold_done = 1'b0;
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;

  // q1.15 sine of rom entry e: quarter-turn fold, taylor series to x^11 in q30
  function automatic int rom_sine(int unsigned e);
    longint unsigned f, r, x, x2, t, s, v;
    logic [1:0] quad;
    f = longint'(e) << 22;
    quad = f[31:30];
    r = f & ((64'd1 << 30) - 1);
    if (quad[0]) begin
      r = (64'd1 << 30) - r;
    end
    x  = (r * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    t  = 64'd1 << 30;
    for (int k = 11; k >= 3; k -= 2) begin
      t = (64'd1 << 30) - ((t * x2) >> 30) / longint'(k * (k - 1));
    end
    s = (x * t) >> 30;
    v = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return quad[1] ? -int'(v) : int'(v);
  endfunction

  function automatic int wave_sine(logic [31:0] phase);
    return sine_rom[phase[31:22]];
  endfunction

  // coordinate wave phase, coord degrees scaled by a q1.15 frame sine
  function automatic logic [31:0] scaled_turn(int unsigned coord, int scale);
    longint p;
    logic [63:0] u;
    p = longint'(coord) * 64'sd11930465 * longint'(scale);
    u = p;
    return u[46:15];
  endfunction

  function automatic pixel_color_t predict_color(logic [3:0] px, logic [3:0] py,
                                                 logic [15:0] frame);
    pixel_color_t res;
    int unsigned cnt, xc, yc, step4, p, o, m, idx;
    int c1, c2, s1, s2, s3;
    longint sum;
    logic [31:0] ph, ft;
    logic [RgbW-1:0] a, c;
    cnt = 32'(pal_count);
    if (cnt == 0) cnt = 1;
    if (cnt > 5) cnt = 5;
    xc = 20 + 32'(px);
    yc = 20 + 32'(py);
    ft = 32'(frame);
    c1 = wave_sine(ft * 32'd7355802);
    c2 = wave_sine(32'd0 - ft * 32'd43369936);
    s1 = wave_sine(scaled_turn(xc, c1));
    s2 = wave_sine(scaled_turn(yc, c2));
    ph = (xc + yc + 3 * ft) * 32'd5965232;
    s3 = wave_sine(ph);
    sum = 128 * (longint'(98304) + s1 + s2 + s3);
    idx = int'(((sum + 16384) >>> 15) % 255);
    // palette walk: strip whole steps of 255/count, exact in quarters
    step4 = 1020 / cnt;
    p = idx;
    o = 0;
    while (p * 4 > step4) begin
      p = (p * 4 - step4) / 4;
      o++;
    end
    a = pal_anchor[(o + 1) % cnt];
    c = pal_anchor[o % cnt];
    m = p * cnt;
    if (m > 255) m = 255;
    for (int sh = 0; sh <= 16; sh += 8) begin
      res.rgb[sh +: 8] = 8'((a[sh +: 8] * m + c[sh +: 8] * (255 - m)) >> 8);
    end
    res.idx = idx[7:0];
    return res;
  endfunction

  // stop offering, then wait until every expected color is back and the unit has gone quiet
  task automatic settle();
    @(negedge clk);
    pix_in.valid = 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [RgbW-1:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_COLOR_COUNT) begin
      pal_count = data[2:0];
    end else if (idx <= REG_COLOR_FOUR) begin
      pal_anchor[idx - 1] = data;
    end
  endtask

  // offer one request, with burst gaps in front; logs the expectation on acceptance
  task automatic send_pixel(logic [3:0] px, logic [3:0] py, logic [15:0] frame,
                            bit has_rgb, logic [RgbW-1:0] rgb);
    int unsigned gap;
    pixel_color_t want;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    end
    burst_left--;
    if (gap > 0) begin
      @(negedge clk);
      pix_in.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    pix_in.pixel_x = px;
    pix_in.pixel_y = py;
    pix_in.frame_number = frame;
    pix_in.valid = 1'b1;
    do @(posedge clk); while (!pix_in.ready);
    want = predict_color(px, py, frame);
    if (has_rgb) begin
      want.rgb = rgb;
    end
    pending_colors.push_back(want);
    sent_cnt++;
  endtask

  // directed table; rgb typed in where it follows at once (reset palette at frame zero,
  // single anchor of full white or black)
  plasma_row_t plasma_rows [] = '{
    '{0, REG_COLOR_COUNT, 0, 4'd0,  4'd0,  16'd0,     1, 24'he4854f},
    '{0, REG_COLOR_COUNT, 0, 4'd15, 4'd15, 16'd0,     0, 0},
    '{0, REG_COLOR_COUNT, 0, 4'd0,  4'd15, 16'hffff,  0, 0},
    '{0, REG_COLOR_COUNT, 0, 4'd15, 4'd0,  16'hffff,  0, 0},
    '{0, REG_COLOR_COUNT, 0, 4'd7,  4'd8,  16'd1,     0, 0},
    '{0, REG_COLOR_COUNT, 0, 4'd8,  4'd7,  16'h8000,  0, 0},
    '{0, REG_COLOR_COUNT, 0, 4'd5,  4'd10, 16'h5555,  0, 0},
    '{0, REG_COLOR_COUNT, 0, 4'd10, 4'd5,  16'haaaa,  0, 0},
    '{0, REG_COLOR_COUNT, 0, 4'd3,  4'd12, 16'd12345, 0, 0},
    // one anchor in use: every pixel gets that anchor scaled by 255/256
    '{1, REG_COLOR_COUNT, 24'd1,        4'd5,  4'd9,  16'd777,  0, 0},
    '{1, REG_COLOR_ZERO,  24'hffffff,   4'd5,  4'd9,  16'd777,  1, 24'hfefefe},
    '{1, REG_COLOR_ZERO,  24'h000000,   4'd2,  4'd14, 16'd4000, 1, 24'h000000},
    // count zero falls back to one anchor
    '{1, REG_COLOR_COUNT, 24'd0,        4'd11, 4'd3,  16'd999,  1, 24'h000000},
    '{1, REG_COLOR_ZERO,  24'hffffff,   4'd0,  4'd0,  16'hffff, 1, 24'hfefefe},
    // count six and seven fall back to five
    '{1, REG_COLOR_COUNT, 24'd7,        4'd9,  4'd9,  16'd31,   0, 0},
    '{1, REG_COLOR_COUNT, 24'd6,        4'd1,  4'd13, 16'd2024, 0, 0},
    // writes past the last color register are dropped
    '{1, REG_SPARE_SIX,   24'h123456,   4'd6,  4'd6,  16'd60,   0, 0},
    '{1, REG_SPARE_SEVEN, 24'hffffff,   4'd12, 4'd4,  16'd61,   0, 0},
    '{1, REG_COLOR_COUNT, 24'hfffffa,   4'd4,  4'd12, 16'd300,  0, 0},
    '{1, REG_COLOR_COUNT, 24'd5,        4'd14, 4'd1,  16'd301,  0, 0}
  };

  // receiver: stall patterns of varying density, one long hold-off so the unit backs up
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      pix_out.ready = 1'b0;
      hold_cnt--;
    end else if (!hold_done && sent_cnt >= 60) begin
      hold_done = 1'b1;
      hold_cnt = HOLD_LEN;
      pix_out.ready = 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(5, 60);
      end
      rx_left--;
      case (rx_mode)
        0: begin
          pix_out.ready = 1'b1;
        end
        1: begin
          pix_out.ready = 1'($urandom_range(0, 1));
        end
        default: begin
          pix_out.ready = ($urandom_range(0, 7) == 0);
        end
      endcase
    end
  end

  // result check against the oldest expected color
  always @(posedge clk) begin
    pixel_color_t want;
    if (!rst && pix_out.valid && pix_out.ready) begin
      if (pending_colors.size() == 0) begin
        $error("unexpected result rgb %h index %0d", pix_out.pixel_rgb, pix_out.palette_index);
        fail_cnt++;
      end else begin
        want = pending_colors.pop_front();
        if (pix_out.pixel_rgb !== want.rgb) begin
          $error("pixel_rgb expected %h actual %h", want.rgb, pix_out.pixel_rgb);
          fail_cnt++;
        end
        if (pix_out.palette_index !== want.idx) begin
          $error("palette_index expected %0d actual %0d", want.idx, pix_out.palette_index);
          fail_cnt++;
        end
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic [3:0] rx, ry;
    logic [15:0] rf;
    logic [2:0] cnt_pick [SETTINGS_N] = '{3'd1, 3'd5, 3'd2, 3'd0, 3'd3, 3'd7, 3'd4, 3'd6};
    pix_in.valid = 1'b0;
    pix_in.pixel_x = '0;
    pix_in.pixel_y = '0;
    pix_in.frame_number = '0;
    pix_out.ready = 1'b0;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      sine_rom[i] = rom_sine(i);
    end
    pal_count = 3'd5;
    pal_anchor = '{COLOR_ZERO_RST, COLOR_ONE_RST, COLOR_TWO_RST, COLOR_THREE_RST,
                   COLOR_FOUR_RST};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    foreach (plasma_rows[i]) begin
      if (plasma_rows[i].wr) begin
        settle();
        write_reg(plasma_rows[i].reg_idx, plasma_rows[i].reg_data);
      end
      send_pixel(plasma_rows[i].x, plasma_rows[i].y, plasma_rows[i].frame,
                 plasma_rows[i].has_rgb, plasma_rows[i].rgb);
    end

    // random pixels under a sweep of palette settings, extremes included
    for (int s = 0; s < SETTINGS_N; s++) begin
      settle();
      write_reg(REG_COLOR_COUNT, {21'($urandom), cnt_pick[s]});
      for (int r = REG_COLOR_ZERO; r <= REG_COLOR_FOUR; r++) begin
        case ($urandom_range(0, 3))
          0: write_reg(r[2:0], 24'h000000);
          1: write_reg(r[2:0], 24'hffffff);
          default: write_reg(r[2:0], 24'($urandom));
        endcase
      end
      if (s == 3) begin
        write_reg(REG_SPARE_SIX, 24'($urandom));
      end
      for (int n = 0; n < RAND_ITEMS; n++) begin
        rx = 4'($urandom_range(0, 15));
        ry = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 9))
          0: rf = 16'h0000;
          1: rf = 16'hffff;
          default: rf = 16'($urandom_range(0, 65535));
        endcase
        send_pixel(rx, ry, rf, 1'b0, '0);
      end
    end

    @(negedge clk);
    pix_in.valid = 1'b0;
    settle();
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
